### rtl/core/gist_pkg.sv
// Shared types, codes and helpers for the gamepad input state tracker.
`timescale 1ns / 1ps
package gist_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] RegOwnId    = 2'd0;
  localparam logic [1:0] RegDeadZone = 2'd1;
  localparam logic [1:0] RegRptUp    = 2'd2;
  localparam logic [1:0] RegRptHeld  = 2'd3;

  localparam logic [14:0] DeadZoneRst = 15'd3277;
  localparam logic [5:0]  NoButton    = 6'd63;

  localparam logic signed [16:0] StickMax = 17'sd32767;
  localparam logic signed [16:0] StickMin = -17'sd32767;

  typedef enum logic [1:0] {
    MODE_BUTTON = 2'd0,
    MODE_AXIS   = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KS_UP       = 2'd0,
    KS_DOWN     = 2'd1,
    KS_HELD     = 2'd2,
    KS_RELEASED = 2'd3
  } key_state_e;

  typedef enum logic [2:0] {
    KIND_BUTTON = 3'd0,
    KIND_LSTICK = 3'd1,
    KIND_RSTICK = 3'd2,
    KIND_LTRIG  = 3'd3,
    KIND_RTRIG  = 3'd4
  } kind_e;

  // One result word, before last_of_run is known.
  typedef struct packed {
    kind_e             kind;
    logic [4:0]        btn;
    key_state_e        st;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } res_t;

  // Clamp a stick component to +-full scale, then zero it inside the deadzone.
  function automatic logic signed [15:0] norm_stick(logic signed [16:0] v,
                                                    logic [14:0] dz);
    logic signed [16:0] c;
    logic [15:0]        mag;
    if (v > StickMax) begin
      c = StickMax;
    end else if (v < StickMin) begin
      c = StickMin;
    end else begin
      c = v;
    end
    mag = c[16] ? 16'(-c) : c[15:0];
    if (mag <= {1'b0, dz}) begin
      norm_stick = 16'sd0;
    end else begin
      norm_stick = c[15:0];
    end
  endfunction

endpackage

### rtl/core/gist_bmem.sv
// Button state memory: one write port, one registered read port.
`timescale 1ns / 1ps
module gist_bmem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [1:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [1:0]    rd_data_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold the read word while the walk is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/gist_axis.sv
// Stick and trigger value registers with clamp and, for the sticks, deadzone normalization.
`timescale 1ns / 1ps
module gist_axis (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic [2:0]        axis_i,
  input  logic signed [15:0] value_i,
  input  logic [14:0]       dead_zone_i,
  output logic [3:0][15:0]  stick_o,
  output logic [1:0][14:0]  trig_o
);
  import gist_pkg::*;

  logic [3:0][15:0]   stick_q, stick_d;
  logic [1:0][14:0]   trig_q, trig_d;
  logic signed [16:0] raw_w, in_w;

  always_comb begin
    raw_w   = 17'(value_i);
    // Y axes come in inverted.
    in_w    = axis_i[0] ? -raw_w : raw_w;
    stick_d = stick_q;
    trig_d  = trig_q;
    for (int k = 0; k < 4; k++) begin
      if (axis_i == 3'(k)) begin
        stick_d[k] = norm_stick(in_w, dead_zone_i);
      end else begin
        stick_d[k] = norm_stick(17'(signed'(stick_q[k])), dead_zone_i);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (axis_i == 3'(k + 4)) begin
        trig_d[k] = value_i[15] ? 15'd0 : value_i[14:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_q <= '0;
      trig_q  <= '0;
    end else if (upd_i) begin
      stick_q <= stick_d;
      trig_q  <= trig_d;
    end
  end

  assign stick_o = stick_q;
  assign trig_o  = trig_q;

endmodule

### rtl/core/gist_out.sv
// Result staging: a pending word that waits for its last flag or a newer word, then the output register.
`timescale 1ns / 1ps
module gist_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_vld_i,
  input  gist_pkg::res_t      res_i,
  input  logic                run_end_i,
  output logic                slot_ok_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // which_button, key_state, value_x, value_y
  output logic [2:0]          m_axis_tuser,  // event_kind
  output logic                m_axis_tlast
);
  import gist_pkg::*;

  logic out_vld_q, out_vld_d;
  logic pend_vld_q, pend_vld_d;
  logic pend_last_q, pend_last_d;
  logic out_last_q;
  res_t pend_q, out_q;
  logic out_free, push;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign slot_ok_o = !pend_vld_q || out_free;
  // A pending word leaves once it is known to be last, or once a newer word follows it.
  assign push      = pend_vld_q && out_free && (pend_last_q || res_vld_i);

  always_comb begin
    out_vld_d   = (out_vld_q && !m_axis_tready) || push;
    pend_vld_d  = pend_vld_q && !push;
    pend_last_d = pend_last_q && !push;
    if (res_vld_i) begin
      pend_vld_d  = 1'b1;
      pend_last_d = 1'b0;
    end else if (run_end_i && pend_vld_q && !push) begin
      pend_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      out_vld_q   <= out_vld_d;
      pend_vld_q  <= pend_vld_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= pend_last_q;
    end
    if (res_vld_i) begin
      pend_q <= res_i;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.vy, out_q.vx, out_q.st, out_q.btn};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_last_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_last_q |-> pend_vld_q)
    else $error("last flag set on an empty pending slot");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_i |-> slot_ok_o)
    else $error("result offered while the pending slot cannot take it");
`endif

endmodule

### rtl/core/gamepad_input_state_tracker.sv
// Top level of the gamepad input state tracker: config port, sequencer and state.
`timescale 1ns / 1ps
// Tracks one gamepad. One input word is taken at a time. A button event gives
// one result; an axis event gives one result for a stick axis, or no result
// for a trigger or a spare axis number; an ignored word gives no result. A tick
// walks the button state memory, one entry per cycle over its single read port
// while no result stalls on the output, followed by one step for each trigger;
// it gives up to BUTTONS + 2 results, and each may hold the walk or a trigger
// step while the output is stalled. The next word is taken while earlier
// results still wait at the output. Results leave in order, and tlast marks
// the final result caused by one input word.
module gamepad_input_state_tracker #(
  parameter int unsigned BUTTONS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // device_id, button_number, pressed, axis_number, axis_value
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // which_button, key_state, value_x, value_y
  output logic [2:0]  m_axis_tuser,  // event_kind
  output logic        m_axis_tlast
);
  import gist_pkg::*;

  localparam int unsigned AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [5:0]  LastIdx = 6'(BUTTONS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_AXOUT = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_TRIG0 = 7'b0010000,
    S_TRIG1 = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  // Configuration
  logic [15:0] own_id_q;
  logic [14:0] dz_q;
  logic        rpt_up_q, rpt_held_q;
  logic        cfg_wr;

  // Captured input word
  mode_e              in_mode_q;
  logic [15:0]        in_dev_q;
  logic [4:0]         in_btn_q;
  logic               in_prs_q;
  logic [2:0]         in_axis_q;
  logic signed [15:0] in_val_q;

  // Control state
  state_e             state_q, state_d;
  logic [BUTTONS-1:0] seen_q, seen_d;
  logic [5:0]         last_q, last_d;
  key_state_e         tst_q [2];
  key_state_e         tst_d [2];
  logic [5:0]         ptr_q, ptr_d;
  logic               p_vld_q, p_vld_d;
  logic [5:0]         p_idx_q, p_idx_d;

  // Datapath
  logic              accept;
  logic              dev_ok, btn_ok;
  logic [5:0]        btn6;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr;
  logic [1:0]        wr_data, rd_data;
  logic              ax_upd;
  logic [3:0][15:0]  stick_w;
  logic [1:0][14:0]  trig_w;
  logic              res_vld, run_end, slot_ok;
  res_t              res;
  key_state_e        cur_b, ns_b;
  logic              active, emit_b, stall;
  logic              t_sel, t_on, t_rep;
  key_state_e        t_cur, t_ns;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= 16'd0;
      dz_q       <= DeadZoneRst;
      rpt_up_q   <= 1'b0;
      rpt_held_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegOwnId:    own_id_q   <= pwdata[15:0];
        RegDeadZone: dz_q       <= pwdata[14:0];
        RegRptUp:    rpt_up_q   <= pwdata[0];
        RegRptHeld:  rpt_held_q <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegOwnId:    prdata = {16'd0, own_id_q};
      RegDeadZone: prdata = {17'd0, dz_q};
      RegRptUp:    prdata = {31'd0, rpt_up_q};
      RegRptHeld:  prdata = {31'd0, rpt_held_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q <= mode_e'(s_axis_tuser);
      in_dev_q  <= s_axis_tdata[15:0];
      in_btn_q  <= s_axis_tdata[20:16];
      in_prs_q  <= s_axis_tdata[21];
      in_axis_q <= s_axis_tdata[24:22];
      in_val_q  <= s_axis_tdata[40:25];
    end
  end

  assign dev_ok = (in_dev_q == own_id_q);
  assign btn6   = {1'b0, in_btn_q};
  assign btn_ok = (btn6 < LastIdx);

  // Walk stage: age the entry that the registered read port holds.
  always_comb begin
    cur_b  = key_state_e'(rd_data);
    active = p_vld_q && seen_q[p_idx_q[AW-1:0]] && (p_idx_q != last_q);
    unique case (cur_b)
      KS_DOWN:     ns_b = KS_HELD;
      KS_RELEASED: ns_b = KS_UP;
      default:     ns_b = cur_b;
    endcase
    emit_b = active && ((ns_b == KS_UP && rpt_up_q) || (ns_b == KS_HELD && rpt_held_q));
    stall  = emit_b && !slot_ok;
  end

  // Trigger step for the trigger named by the current state.
  always_comb begin
    t_sel = (state_q == S_TRIG1);
    t_on  = (trig_w[t_sel] > dz_q);
    t_cur = tst_q[t_sel];
    unique case (t_cur)
      KS_UP: begin
        t_ns  = t_on ? KS_DOWN : KS_UP;
        t_rep = t_on || rpt_up_q;
      end
      KS_DOWN: begin
        t_ns  = t_on ? KS_HELD : KS_RELEASED;
        t_rep = t_on ? rpt_held_q : 1'b1;
      end
      KS_HELD: begin
        t_ns  = t_on ? KS_HELD : KS_RELEASED;
        t_rep = t_on ? rpt_held_q : 1'b1;
      end
      default: begin
        t_ns  = t_on ? KS_DOWN : KS_UP;
        t_rep = t_on || rpt_up_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    seen_d   = seen_q;
    last_d   = last_q;
    tst_d    = tst_q;
    ptr_d    = ptr_q;
    p_vld_d  = p_vld_q;
    p_idx_d  = p_idx_q;
    wr_en    = 1'b0;
    wr_addr  = btn6[AW-1:0];
    wr_data  = in_prs_q ? KS_DOWN : KS_RELEASED;
    rd_en    = 1'b0;
    ax_upd   = 1'b0;
    res_vld  = 1'b0;
    res      = '0;
    run_end  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (in_mode_q)
          MODE_BUTTON: begin
            if (!(dev_ok && btn_ok)) begin
              state_d = S_FIN;
            end else if (slot_ok) begin
              wr_en                = 1'b1;
              seen_d[btn6[AW-1:0]] = 1'b1;
              last_d               = btn6;
              res_vld              = 1'b1;
              res.kind             = KIND_BUTTON;
              res.btn              = in_btn_q;
              res.st               = key_state_e'(wr_data);
              state_d              = S_FIN;
            end
          end
          MODE_AXIS: begin
            ax_upd  = dev_ok;
            state_d = (dev_ok && !in_axis_q[2]) ? S_AXOUT : S_FIN;
          end
          MODE_TICK: begin
            ptr_d   = 6'd0;
            p_vld_d = 1'b0;
            state_d = S_WALK;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_AXOUT: begin
        if (slot_ok) begin
          res_vld  = 1'b1;
          res.kind = in_axis_q[1] ? KIND_RSTICK : KIND_LSTICK;
          res.vx   = stick_w[{in_axis_q[1], 1'b0}];
          res.vy   = stick_w[{in_axis_q[1], 1'b1}];
          state_d  = S_FIN;
        end
      end
      S_WALK: begin
        if (!stall) begin
          wr_en   = active;
          wr_addr = p_idx_q[AW-1:0];
          wr_data = ns_b;
          if (emit_b) begin
            res_vld  = 1'b1;
            res.kind = KIND_BUTTON;
            res.btn  = p_idx_q[4:0];
            res.st   = ns_b;
          end
          // Read the next entry while the current one is written back.
          if (ptr_q < LastIdx) begin
            rd_en   = 1'b1;
            ptr_d   = ptr_q + 6'd1;
            p_vld_d = 1'b1;
            p_idx_d = ptr_q;
          end else begin
            p_vld_d = 1'b0;
            state_d = S_TRIG0;
          end
        end
      end
      S_TRIG0, S_TRIG1: begin
        if (!(t_rep && !slot_ok)) begin
          tst_d[t_sel] = t_ns;
          if (t_rep) begin
            res_vld  = 1'b1;
            res.kind = t_sel ? KIND_RTRIG : KIND_LTRIG;
            res.st   = t_ns;
            res.vx   = {1'b0, trig_w[t_sel]};
          end
          if (t_sel) begin
            last_d  = NoButton;
            state_d = S_FIN;
          end else begin
            state_d = S_TRIG1;
          end
        end
      end
      S_FIN: begin
        run_end = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      seen_q   <= '0;
      last_q   <= NoButton;
      tst_q[0] <= KS_UP;
      tst_q[1] <= KS_UP;
      ptr_q    <= 6'd0;
      p_vld_q  <= 1'b0;
      p_idx_q  <= 6'd0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
      tst_q   <= tst_d;
      ptr_q   <= ptr_d;
      p_vld_q <= p_vld_d;
      p_idx_q <= p_idx_d;
    end
  end

  gist_bmem #(
    .DEPTH (BUTTONS),
    .AW    (AW)
  ) u_bmem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  gist_axis u_axis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (ax_upd),
    .axis_i      (in_axis_q),
    .value_i     (in_val_q),
    .dead_zone_i (dz_q),
    .stick_o     (stick_w),
    .trig_o      (trig_w)
  );

  gist_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_vld_i     (res_vld),
    .res_i         (res),
    .run_end_i     (run_end),
    .slot_ok_o     (slot_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastIdx)
    else $error("walk pointer ran past the button table");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en && (wr_addr == ptr_q[AW-1:0])))
    else $error("button memory read and written at the same entry");
  a_walk_ends_in_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && state_d != S_WALK) |-> !p_vld_d)
    else $error("walk left with an entry still in flight");
`endif

endmodule
